[hdl/assert_macros.svh]
// assertion macros shared by the sorted in-degree counter rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SIDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true outside reset
`define SIDC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/sidc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the sorted in-degree counter
// no dependencies
package sidc_pkg;

  localparam int unsigned MaxLinksDef = 64;
  localparam int unsigned NodeW       = 32;
  localparam int unsigned DegW        = 7;
  localparam int unsigned InTdataW    = 32;
  localparam int unsigned OutTdataW   = 40;

  typedef struct packed {
    logic [NodeW-1:0] target_node;
    logic [DegW-1:0]  in_degree;
    logic             end_of_run;
    logic             overflowed;
  } result_t;

endpackage

[hdl/sidc_link_mem.sv]
`timescale 1ns / 1ps
// link store: one write port, one read port with registered read data
// depends on sidc_pkg
module sidc_link_mem #(
  parameter int unsigned Depth = sidc_pkg::MaxLinksDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [sidc_pkg::NodeW-1:0] wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [sidc_pkg::NodeW-1:0] rdata_o
);

  logic [sidc_pkg::NodeW-1:0] mem_q [Depth];
  logic [sidc_pkg::NodeW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sidc_out_reg.sv]
`timescale 1ns / 1ps
// output register for result transactions, packs results onto the master stream
// depends on sidc_pkg
module sidc_out_reg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           ld_i,
  input  sidc_pkg::result_t              res_i,
  output logic                           free_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sidc_pkg::OutTdataW-1:0] m_axis_tdata,  // target_node[31:0], in_degree[38:32], pad
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser   // overflowed
);

  logic              valid_q, valid_d;
  sidc_pkg::result_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (ld_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {1'b0, res_q.in_degree, res_q.target_node};
  assign m_axis_tlast  = res_q.end_of_run;
  assign m_axis_tuser  = res_q.overflowed;

endmodule

[hdl/sidc_seq.sv]
`timescale 1ns / 1ps
// sequencer: loads links, insertion-sorts the store in place, drains runs
// depends on sidc_pkg and assert_macros.svh
`include "assert_macros.svh"
module sidc_seq #(
  parameter int unsigned MAX_LINKS = sidc_pkg::MaxLinksDef,
  parameter int unsigned AddrW     = $clog2(MAX_LINKS),
  parameter int unsigned CntW      = $clog2(MAX_LINKS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sidc_pkg::NodeW-1:0] in_dest_i,
  input  logic                       in_final_i,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output logic [sidc_pkg::NodeW-1:0] mem_wdata_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  input  logic [sidc_pkg::NodeW-1:0] mem_rdata_i,
  output logic                       res_ld_o,
  output sidc_pkg::result_t          res_o,
  input  logic                       res_free_i
);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_KEY    = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_DPRIME = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_FLUSH  = 3'd6;

  localparam logic [CntW-1:0] CntFull = CntW'(MAX_LINKS);

  logic [2:0]                 state_q, state_d;
  logic [CntW-1:0]            count_q, count_d;
  logic                       drop_q, drop_d;
  logic [AddrW-1:0]           i_q, i_d;
  logic [AddrW-1:0]           j_q, j_d;
  logic [AddrW-1:0]           k_q, k_d;
  logic [sidc_pkg::NodeW-1:0] key_q, key_d;
  logic [sidc_pkg::NodeW-1:0] cur_q, cur_d;
  logic [sidc_pkg::DegW-1:0]  run_q, run_d;
  logic [CntW-1:0]            cnt_m1;
  logic [AddrW-1:0]           last_idx;
  logic                       accept;
  logic                       adv;

  assign cnt_m1   = count_q - 1'b1;
  assign last_idx = cnt_m1[AddrW-1:0];
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    key_d       = key_q;
    cur_d       = cur_q;
    run_d       = run_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = in_dest_i;
    mem_raddr_o = '0;
    res_ld_o    = 1'b0;
    res_o       = '{target_node: cur_q, in_degree: run_q, end_of_run: 1'b0, overflowed: drop_q};
    adv         = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (count_q != CntFull) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = count_q[AddrW-1:0];
            count_d     = count_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (in_final_i) begin
            if (count_d >= CntW'(2)) begin
              i_d     = AddrW'(1);
              state_d = ST_START;
            end else begin
              k_d     = '0;
              state_d = ST_DPRIME;
            end
          end
        end
      end
      ST_START: begin
        mem_raddr_o = i_q;
        state_d     = ST_KEY;
      end
      ST_KEY: begin
        key_d       = mem_rdata_i;
        j_d         = i_q;
        mem_raddr_o = i_q - 1'b1;
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = j_q;
        if (j_q != '0 && mem_rdata_i > key_q) begin
          mem_wdata_o = mem_rdata_i;
          j_d         = j_q - 1'b1;
          mem_raddr_o = j_q - 1'b1 - 1'b1;
        end else begin
          mem_wdata_o = key_q;
          if (i_q == last_idx) begin
            k_d     = '0;
            state_d = ST_DPRIME;
          end else begin
            i_d         = i_q + 1'b1;
            mem_raddr_o = i_q + 1'b1;
            state_d     = ST_KEY;
          end
        end
      end
      ST_DPRIME: begin
        mem_raddr_o = k_q;
        state_d     = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (k_q == '0) begin
          cur_d = mem_rdata_i;
          run_d = sidc_pkg::DegW'(1);
          adv   = 1'b1;
        end else if (mem_rdata_i == cur_q) begin
          run_d = run_q + 1'b1;
          adv   = 1'b1;
        end else if (res_free_i) begin
          res_ld_o = 1'b1;
          cur_d    = mem_rdata_i;
          run_d    = sidc_pkg::DegW'(1);
          adv      = 1'b1;
        end
        if (adv) begin
          if (k_q == last_idx) begin
            state_d = ST_FLUSH;
          end else begin
            k_d         = k_q + 1'b1;
            mem_raddr_o = k_q + 1'b1;
          end
        end else begin
          mem_raddr_o = k_q;
        end
      end
      ST_FLUSH: begin
        res_o.end_of_run = 1'b1;
        if (res_free_i) begin
          res_ld_o = 1'b1;
          count_d  = '0;
          drop_d   = 1'b0;
          state_d  = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
    key_q <= key_d;
    cur_q <= cur_d;
    run_q <= run_d;
  end

  `SIDC_ASSERT(a_count_bound, count_q <= CntFull, "stored link count beyond capacity")
  `SIDC_ASSERT(a_sort_wr_in_set, (mem_we_o && state_q != ST_LOAD) |-> (CntW'(mem_waddr_o) < count_q), "sort write outside the stored set")
  `SIDC_ASSERT(a_clear_after_last, (res_ld_o && res_o.end_of_run) |=> (count_q == '0 && !drop_q && state_q == ST_LOAD), "set not cleared after final result")
  `SIDC_NEVER(a_zero_degree, res_ld_o && res_o.in_degree == '0, "result with zero in-degree")

endmodule

[hdl/sorted_indegree_counter_top.sv]
`timescale 1ns / 1ps
// Links stream in at one per cycle while loading and are written to a single-port-write
// link store of MAX_LINKS entries; links beyond capacity are dropped and flag every result
// of the set. After the link marked tlast, a store of two or more links is insertion-sorted
// in place, one key at a time, shifting each larger entry up before the key is written back,
// through the one read and one write port of the store. The sorted store is then read one
// entry per cycle, stalling when a run ends with the output register full, with one result
// per distinct destination; no links are taken from sort start to the final result.
// Depends on sidc_pkg, sidc_link_mem, sidc_seq, sidc_out_reg.
module sorted_indegree_counter_top #(
  parameter int unsigned MAX_LINKS = sidc_pkg::MaxLinksDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sidc_pkg::InTdataW-1:0]  s_axis_tdata,   // dest_node[31:0]
  input  logic                           s_axis_tlast,   // final_link
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sidc_pkg::OutTdataW-1:0] m_axis_tdata,   // target_node[31:0], in_degree[38:32]
  output logic                           m_axis_tlast,   // end_of_run
  output logic                           m_axis_tuser    // overflowed
);

  localparam int unsigned AddrW = $clog2(MAX_LINKS);
  localparam int unsigned CntW  = $clog2(MAX_LINKS + 1);

  logic                       mem_we;
  logic [AddrW-1:0]           mem_waddr;
  logic [sidc_pkg::NodeW-1:0] mem_wdata;
  logic [AddrW-1:0]           mem_raddr;
  logic [sidc_pkg::NodeW-1:0] mem_rdata;
  logic                       res_ld;
  logic                       res_free;
  sidc_pkg::result_t          res;

  sidc_link_mem #(
    .Depth (MAX_LINKS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sidc_seq #(
    .MAX_LINKS (MAX_LINKS),
    .AddrW     (AddrW),
    .CntW      (CntW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_dest_i   (s_axis_tdata[sidc_pkg::NodeW-1:0]),
    .in_final_i  (s_axis_tlast),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_ld_o    (res_ld),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  sidc_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ld_i          (res_ld),
    .res_i         (res),
    .free_o        (res_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
